// File: hdl/first_fit_heap_allocator_macros.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define FFHA_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication checked on every clock edge outside reset.
`define FFHA_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/ffha_pkg.sv
// Shared constants and types of the first-fit heap allocator.
package ffha_pkg;
    localparam int HEAP_BYTES = 65536;
    localparam int MAX_BLOCKS = 64;
    localparam int META_BYTES = 24;
    localparam int ALIGN      = 16;

    localparam int BW = 17;                      // byte counts and offsets
    localparam int PW = BW + 1;                  // running sums
    localparam int IW = $clog2(MAX_BLOCKS);      // table index
    localparam int CW = $clog2(MAX_BLOCKS + 1);  // block count

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef struct packed {
        logic          free;
        logic [BW-1:0] bytes;
    } t_entry;
endpackage

// File: hdl/ffha_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module ffha_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_wa,
    input  logic [W-1:0]         i_wd,
    input  logic [$clog2(D)-1:0] i_ra,
    output logic [W-1:0]         o_rd
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;
endmodule

// File: hdl/first_fit_heap_allocator.sv
// A zero-size request or a null free is answered straight from idle; otherwise
// the block table is walked entry by entry, and when a split inserts or a merge
// removes table entries, the entries behind it are moved one by one before the
// result is given.
// One request at a time; busy is high while a request is in work.
// The result strobe o_valid lasts one cycle and cannot be stalled.
// Synchronous active-low reset empties the table and the heap.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_req_type,
    input  logic [15:0]   i_req_size,
    input  logic [BW-1:0] i_req_addr,
    output logic          o_valid,
    output logic [BW-1:0] o_data_addr,
    output logic [1:0]    o_status
);
    `include "first_fit_heap_allocator_macros.svh"

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_NEXT = 7'b0000100,
        S_SHUP = 7'b0001000,
        S_SPL  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_SHDN = 7'b1000000
    } t_state;

    localparam logic [PW-1:0] META_P = PW'(META_BYTES);
    localparam logic [PW:0]   HEAP_P = (PW+1)'(HEAP_BYTES);

    t_state r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic [BW-1:0] r_top, n_top;
    logic r_type, n_type;
    logic [BW-1:0] r_need, n_need;
    logic [BW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_k, n_k;
    logic [PW-1:0] r_pos, n_pos;
    logic r_pf, n_pf;
    logic [BW-1:0] r_pb, n_pb;
    logic [BW-1:0] r_b, n_b;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_wj, n_wj;
    logic r_sv, n_sv;
    logic [1:0] r_d, n_d;
    logic r_ov, n_ov;
    logic [BW-1:0] r_oa, n_oa;
    t_status r_os, n_os;

    logic          we;
    logic [IW-1:0] wa, ra;
    t_entry        wd, q;

    logic [BW-1:0] need_in;
    logic [PW-1:0] here;
    logic          nf;
    logic [BW-1:0] nb;

    ffha_ram #(.W($bits(t_entry)), .D(MAX_BLOCKS)) u_ram (
        .i_clk (i_clk),
        .i_we  (we),
        .i_wa  (wa),
        .i_wd  (wd),
        .i_ra  (ra),
        .o_rd  (q)
    );

    assign need_in = (BW'(i_req_size) + BW'(ALIGN - 1)) & ~BW'(ALIGN - 1);
    assign here    = r_pos + META_P;
    assign nf      = (r_k + CW'(1) < r_total) && q.free;
    assign nb      = q.bytes;

    always_comb begin
        n_state = r_state; n_total = r_total; n_top = r_top;
        n_type = r_type; n_need = r_need; n_addr = r_addr;
        n_k = r_k; n_pos = r_pos; n_pf = r_pf; n_pb = r_pb; n_b = r_b;
        n_j = r_j; n_wj = r_wj; n_sv = r_sv; n_d = r_d;
        n_ov = 1'b0; n_oa = '0; n_os = ST_OK;
        we = 1'b0; wa = '0; wd = '0; ra = '0;
        unique case (r_state)
            S_IDLE: begin
                ra = '0;
                if (start) begin
                    n_type = i_req_type; n_need = need_in; n_addr = i_req_addr;
                    n_k = '0; n_pos = '0; n_pf = 1'b0; n_pb = '0;
                    if (!i_req_type && i_req_size == '0) begin
                        n_ov = 1'b1; n_os = ST_ZERO;
                    end else if (i_req_type && i_req_addr == '0) begin
                        n_ov = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ra = IW'(r_k + CW'(1));
                if (r_k >= r_total) begin
                    n_state = S_IDLE; n_ov = 1'b1;
                    if (r_type) begin
                        n_os = ST_BAD_FREE;
                    end else if (r_total >= CW'(MAX_BLOCKS) ||
                                 (PW+1)'(r_top) + (PW+1)'(META_P) + (PW+1)'(r_need) > HEAP_P) begin
                        n_os = ST_NO_SPACE;
                    end else begin
                        we = 1'b1; wa = IW'(r_total); wd = '{free: 1'b0, bytes: r_need};
                        n_total = r_total + CW'(1);
                        n_oa = r_top + BW'(META_BYTES);
                        n_top = r_top + BW'(META_BYTES) + r_need;
                    end
                end else if (!r_type && q.free && q.bytes >= r_need) begin
                    n_oa = here[BW-1:0];
                    if (PW'(q.bytes) > PW'(r_need) + META_P && r_total < CW'(MAX_BLOCKS)) begin
                        n_b = q.bytes; n_j = r_total - CW'(1); n_sv = 1'b0;
                        n_state = S_SHUP;
                    end else begin
                        we = 1'b1; wa = IW'(r_k); wd = '{free: 1'b0, bytes: q.bytes};
                        n_ov = 1'b1; n_state = S_IDLE;
                    end
                end else if (r_type && here == PW'(r_addr)) begin
                    if (q.free) begin
                        n_ov = 1'b1; n_os = ST_BAD_FREE; n_state = S_IDLE;
                    end else begin
                        n_b = q.bytes; n_state = S_NEXT;
                    end
                end else begin
                    n_k = r_k + CW'(1);
                    n_pos = here + PW'(q.bytes);
                    n_pf = q.free; n_pb = q.bytes;
                end
            end
            S_NEXT: begin
                we = 1'b1; n_sv = 1'b0;
                priority if (r_pf && nf) begin
                    wa = IW'(r_k - CW'(1));
                    wd = '{free: 1'b1, bytes: r_pb + r_b + nb + BW'(2 * META_BYTES)};
                    n_d = 2'd2; n_j = r_k + CW'(2); n_state = S_SHDN;
                end else if (r_pf) begin
                    wa = IW'(r_k - CW'(1));
                    wd = '{free: 1'b1, bytes: r_pb + r_b + BW'(META_BYTES)};
                    n_d = 2'd1; n_j = r_k + CW'(1); n_state = S_SHDN;
                end else if (nf) begin
                    wa = IW'(r_k);
                    wd = '{free: 1'b1, bytes: r_b + nb + BW'(META_BYTES)};
                    n_d = 2'd1; n_j = r_k + CW'(2); n_state = S_SHDN;
                end else begin
                    wa = IW'(r_k);
                    wd = '{free: 1'b1, bytes: r_b};
                    n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            S_SHUP: begin
                if (r_sv) begin
                    we = 1'b1; wa = IW'(r_wj + CW'(1)); wd = q;
                end
                ra = IW'(r_j);
                if (r_j > r_k) begin
                    n_wj = r_j; n_sv = 1'b1; n_j = r_j - CW'(1);
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_state = S_SPL;
                    end
                end
            end
            S_SPL: begin
                we = 1'b1; wa = IW'(r_k + CW'(1));
                wd = '{free: 1'b1, bytes: r_b - r_need - BW'(META_BYTES)};
                n_total = r_total + CW'(1);
                n_state = S_FIN;
            end
            S_FIN: begin
                we = 1'b1; wa = IW'(r_k); wd = '{free: 1'b0, bytes: r_need};
                n_ov = 1'b1; n_oa = r_oa; n_state = S_IDLE;
            end
            S_SHDN: begin
                if (r_sv) begin
                    we = 1'b1; wa = IW'(r_wj - CW'(r_d)); wd = q;
                end
                ra = IW'(r_j);
                if (r_j < r_total) begin
                    n_wj = r_j; n_sv = 1'b1; n_j = r_j + CW'(1);
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_total = r_total - CW'(r_d);
                        n_ov = 1'b1; n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_SCAN || r_state == S_SHUP || r_state == S_SPL) begin
            if (!n_ov) begin
                n_oa = (r_state == S_SCAN && n_state == S_SHUP) ? n_oa : r_oa;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_top   <= '0;
            r_ov    <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_top   <= n_top;
            r_ov    <= n_ov;
            r_sv    <= n_sv;
        end
        r_type <= n_type; r_need <= n_need; r_addr <= n_addr;
        r_k <= n_k; r_pos <= n_pos; r_pf <= n_pf; r_pb <= n_pb; r_b <= n_b;
        r_j <= n_j; r_wj <= n_wj; r_d <= n_d;
        r_oa <= n_oa; r_os <= n_os;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_ov;
    assign o_data_addr = r_ov ? r_oa : '0;
    assign o_status    = r_ov ? r_os : ST_OK;

    `FFHA_ALWAYS(a_total_max, r_total <= CW'(MAX_BLOCKS), "block count over table size")
    `FFHA_ALWAYS(a_top_max, {1'b0, r_top} <= PW'(HEAP_BYTES), "heap top beyond heap")
    `FFHA_IMPLIES(a_err_addr, o_valid && o_status != ST_OK, o_data_addr == '0,
        "failed transaction returned an address")
    `FFHA_IMPLIES(a_resp_src, o_valid, $past(start) || $past(busy),
        "result without a transaction")
endmodule
